/* rtl/core/tli_pkg.sv */
`default_nettype none
package tli_pkg;

  localparam int TableDepth = 256;
  localparam int FracBits   = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CountW     = IdxW + 1;
  localparam int DataW      = 32;
  localparam int MagW       = DataW + 1;
  localparam int DvdW       = MagW + FracBits;
  localparam int ProdW      = DvdW + MagW;
  localparam int CapBit     = 40;
  localparam int SumW       = CapBit + 3;
  localparam int StepW      = 6;
  localparam int DivSteps   = DvdW;
  localparam int MulSteps   = MagW;

  localparam logic [1:0] RegTableCount = 2'd0;
  localparam logic [1:0] RegExtBelow   = 2'd1;
  localparam logic [1:0] RegExtAbove   = 2'd2;

  localparam logic [1:0] RegionBelow = 2'd0;
  localparam logic [1:0] RegionMid   = 2'd1;
  localparam logic [1:0] RegionHit   = 2'd2;
  localparam logic [1:0] RegionAbove = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_W0, S_CHK0, S_W1, S_CHK1, S_SW, S_SP, S_IW, S_IC,
    S_RA, S_LA, S_RBW, S_LB, S_PREP, S_DIV, S_MINIT, S_MUL, S_FIN
  } tli_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_ADDR_LAST, OP_SEARCH_INIT, OP_PROBE, OP_FIX_I,
    OP_PAIR_BELOW, OP_PAIR_MID, OP_PAIR_ABOVE, OP_LATCH_A, OP_LATCH_B, OP_PREP,
    OP_DIV, OP_MUL_INIT, OP_MUL, OP_OUT_Y, OP_OUT_DEG, OP_OUT_LINE
  } tli_op_e;

  typedef struct packed {
    tli_op_e    op;
    logic [1:0] region;
  } tli_cmd_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic hit;
    logic len_zero;
    logic deg;
    logic cnt_zero;
    logic ext_below;
    logic ext_above;
  } tli_stat_t;

endpackage
`default_nettype wire

/* rtl/core/table_linear_interpolator.sv */
// Piecewise-linear lookup table with signed Q16.16 breakpoints.
// Command channel: a transaction is taken when start is high and busy is low.
//   func_i = 0 loads entry_index_i with x_value_i / y_value_i;
//   busy stays low and no result follows. func_i = 1 runs a query on x_value_i.
// Config channel: cfg_valid_i/cfg_ready_o, index 0 table_count, 1 extrapolate
//   below, 2 extrapolate above; ready is always high. Write only while idle.
// A query result shows on the result ports for one cycle with done_o high.
// A query ends in a clamp below or above the table, in a hit found by the binary
//   search (one probe per halving of table_count), or in a line evaluation: a
//   restoring divider forms the slope and a shift-add multiplier the offset.
//   One query is in flight at a time.
// Reset clears the controller and config (table_count 2, clamp both sides);
//   table contents are undefined until loaded. The receiver cannot stall.
`default_nettype none
module table_linear_interpolator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        func_i,
  input  wire logic [tli_pkg::IdxW-1:0]    entry_index_i,
  input  wire logic signed [31:0]          x_value_i,
  input  wire logic signed [31:0]          y_value_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [tli_pkg::CountW-1:0]  cfg_data_i,
  output logic                             done_o,
  output logic signed [31:0]               result_value_o,
  output logic [1:0]                       region_o,
  output logic                             saturated_o,
  output logic                             degenerate_o
);
  import tli_pkg::*;

  tli_cmd_t  cmd;
  tli_stat_t stat;

  tli_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  tli_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .entry_index_i  (entry_index_i),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .region_o       (region_o),
    .saturated_o    (saturated_o),
    .degenerate_o   (degenerate_o)
  );

endmodule
`default_nettype wire

/* rtl/core/tli_ctrl.sv */
`default_nettype none
module tli_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              func_i,
  input  wire tli_pkg::tli_stat_t stat_i,
  output tli_pkg::tli_cmd_t      cmd_o,
  output logic                   busy
);
  import tli_pkg::*;

  tli_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.region  = RegionMid;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func_i) begin
            cmd_o.op = OP_START;
            state_d  = S_W0;
          end else begin
            cmd_o.op = OP_LOAD;
          end
        end
      end
      S_W0: state_d = S_CHK0;
      S_CHK0: begin
        cmd_o.region = RegionBelow;
        if (stat_i.lt) begin
          if (stat_i.ext_below) begin
            cmd_o.op = OP_PAIR_BELOW;
            state_d  = S_RA;
          end else begin
            cmd_o.op = OP_OUT_Y;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_ADDR_LAST;
          state_d  = S_W1;
        end
      end
      S_W1: state_d = S_CHK1;
      S_CHK1: begin
        cmd_o.region = RegionAbove;
        if (stat_i.gt) begin
          if (stat_i.ext_above) begin
            cmd_o.op = OP_PAIR_ABOVE;
            state_d  = S_RA;
          end else begin
            cmd_o.op = OP_OUT_Y;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_SEARCH_INIT;
          state_d  = S_SW;
        end
      end
      S_SW: begin
        if (stat_i.len_zero) begin
          cmd_o.op = OP_FIX_I;
          state_d  = S_IW;
        end else begin
          state_d = S_SP;
        end
      end
      S_SP: begin
        cmd_o.op = OP_PROBE;
        state_d  = S_SW;
      end
      S_IW: state_d = S_IC;
      S_IC: begin
        if (stat_i.hit) begin
          cmd_o.op     = OP_OUT_Y;
          cmd_o.region = RegionHit;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op     = OP_PAIR_MID;
          cmd_o.region = RegionMid;
          state_d      = S_RA;
        end
      end
      S_RA: state_d = S_LA;
      S_LA: begin
        cmd_o.op = OP_LATCH_A;
        state_d  = S_RBW;
      end
      S_RBW: state_d = S_LB;
      S_LB: begin
        cmd_o.op = OP_LATCH_B;
        state_d  = S_PREP;
      end
      S_PREP: begin
        if (stat_i.deg) begin
          cmd_o.op = OP_OUT_DEG;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_PREP;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.cnt_zero) begin
          state_d = S_MINIT;
        end
      end
      S_MINIT: begin
        cmd_o.op = OP_MUL_INIT;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        if (stat_i.cnt_zero) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = OP_OUT_LINE;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/tli_dp.sv */
`default_nettype none
module tli_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tli_pkg::tli_cmd_t           cmd_i,
  output tli_pkg::tli_stat_t               stat_o,
  input  wire logic [tli_pkg::IdxW-1:0]    entry_index_i,
  input  wire logic signed [31:0]          x_value_i,
  input  wire logic signed [31:0]          y_value_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [tli_pkg::CountW-1:0]  cfg_data_i,
  output logic                             done_o,
  output logic signed [31:0]               result_value_o,
  output logic [1:0]                       region_o,
  output logic                             saturated_o,
  output logic                             degenerate_o
);
  import tli_pkg::*;

  logic [DataW-1:0] mem_x [TableDepth];
  logic [DataW-1:0] mem_y [TableDepth];

  logic [CountW-1:0] tcount_q;
  logic              ext_below_q, ext_above_q;
  logic [IdxW-1:0]   addr_q;
  logic signed [DataW-1:0] rdx_q, rdy_q, q_q;
  logic signed [DataW-1:0] xa_q, ya_q, xb_q, yb_q, yc_q;
  logic [IdxW-1:0]   b_q;
  logic              anc_b_q;
  logic [1:0]        reg_q;
  logic [CountW-1:0] first_q, len_q;
  logic [StepW-1:0]  cnt_q;
  logic [DvdW-1:0]   quo_q;
  logic [MagW-1:0]   rem_q, dvs_q, mq_q;
  logic              neg_q;
  logic [ProdW-1:0]  acc_q;

  logic              done_q, sat_q, deg_q;
  logic [1:0]        region_q;
  logic signed [DataW-1:0] res_q;

  logic [CountW-1:0] n;
  logic [CountW-1:0] half, nf, nl, ifix;
  logic [MagW:0]     trial;
  logic              qbit;
  logic signed [MagW-1:0] dx, dy, dq;
  logic [MagW-1:0]   mdx, mdy, mdq;
  logic signed [DataW-1:0] xc;
  logic [ProdW-FracBits-1:0] shp;
  logic [CapBit:0]   mp;
  logic signed [SumW-1:0] ys, mpe, sum;
  logic              ovf;

  always_comb begin
    if (tcount_q < CountW'(2)) begin
      n = CountW'(2);
    end else if (tcount_q > CountW'(TableDepth)) begin
      n = CountW'(TableDepth);
    end else begin
      n = tcount_q;
    end
    half = len_q >> 1;
    if ($signed(rdx_q) < q_q) begin
      nf = first_q + half + CountW'(1);
      nl = len_q - half - CountW'(1);
    end else begin
      nf = first_q;
      nl = half;
    end
    ifix  = (first_q >= n) ? (n - CountW'(1)) : first_q;
    trial = {rem_q, quo_q[DvdW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    dx  = MagW'(xb_q) - MagW'(xa_q);
    dy  = MagW'(yb_q) - MagW'(ya_q);
    xc  = anc_b_q ? xb_q : xa_q;
    dq  = MagW'(q_q) - MagW'(xc);
    mdx = dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
    mdy = dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    mdq = dq[MagW-1] ? MagW'(-dq) : MagW'(dq);
    shp = acc_q[ProdW-1:FracBits];
    mp  = (|shp[ProdW-FracBits-1:CapBit]) ? {1'b1, {CapBit{1'b0}}} : shp[CapBit:0];
    ys  = SumW'(yc_q);
    mpe = $signed({2'b00, mp});
    sum = neg_q ? (ys - mpe) : (ys + mpe);
    ovf = (sum[SumW-1:DataW-1] != {(SumW-DataW+1){1'b0}}) &&
          (sum[SumW-1:DataW-1] != {(SumW-DataW+1){1'b1}});
  end

  always_ff @(posedge clk_i) begin
    rdx_q <= mem_x[addr_q];
    rdy_q <= mem_y[addr_q];
    if (cmd_i.op == OP_LOAD) begin
      mem_x[entry_index_i] <= x_value_i;
      mem_y[entry_index_i] <= y_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q    <= CountW'(2);
      ext_below_q <= 1'b0;
      ext_above_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegTableCount: tcount_q    <= cfg_data_i;
          RegExtBelow:   ext_below_q <= cfg_data_i[0];
          RegExtAbove:   ext_above_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      done_q <= (cmd_i.op == OP_OUT_Y) || (cmd_i.op == OP_OUT_DEG) ||
                (cmd_i.op == OP_OUT_LINE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: begin
        q_q    <= x_value_i;
        addr_q <= '0;
      end
      OP_ADDR_LAST: addr_q <= IdxW'(n - CountW'(1));
      OP_SEARCH_INIT: begin
        first_q <= '0;
        len_q   <= n;
        addr_q  <= IdxW'(n >> 1);
      end
      OP_PROBE: begin
        first_q <= nf;
        len_q   <= nl;
        addr_q  <= IdxW'(nf + (nl >> 1));
      end
      OP_FIX_I: addr_q <= IdxW'(ifix);
      OP_PAIR_BELOW: begin
        b_q     <= IdxW'(1);
        anc_b_q <= 1'b0;
        reg_q   <= cmd_i.region;
        addr_q  <= '0;
      end
      OP_PAIR_MID: begin
        b_q     <= addr_q;
        anc_b_q <= 1'b0;
        reg_q   <= cmd_i.region;
        addr_q  <= addr_q - IdxW'(1);
      end
      OP_PAIR_ABOVE: begin
        b_q     <= IdxW'(n - CountW'(1));
        anc_b_q <= 1'b1;
        reg_q   <= cmd_i.region;
        addr_q  <= IdxW'(n - CountW'(2));
      end
      OP_LATCH_A: begin
        xa_q   <= rdx_q;
        ya_q   <= rdy_q;
        addr_q <= b_q;
      end
      OP_LATCH_B: begin
        xb_q <= rdx_q;
        yb_q <= rdy_q;
      end
      OP_PREP: begin
        dvs_q <= mdx;
        quo_q <= {mdy, {FracBits{1'b0}}};
        rem_q <= '0;
        mq_q  <= mdq;
        neg_q <= dy[MagW-1] ^ dx[MagW-1] ^ dq[MagW-1];
        yc_q  <= anc_b_q ? yb_q : ya_q;
        cnt_q <= StepW'(DivSteps - 1);
      end
      OP_DIV: begin
        rem_q <= qbit ? MagW'(trial - {1'b0, dvs_q}) : MagW'(trial);
        quo_q <= {quo_q[DvdW-2:0], qbit};
        cnt_q <= cnt_q - StepW'(1);
      end
      OP_MUL_INIT: begin
        acc_q <= '0;
        cnt_q <= StepW'(MulSteps - 1);
      end
      OP_MUL: begin
        acc_q <= (acc_q << 1) + (mq_q[MagW-1] ? ProdW'(quo_q) : ProdW'(0));
        mq_q  <= mq_q << 1;
        cnt_q <= cnt_q - StepW'(1);
      end
      OP_OUT_Y: begin
        res_q    <= rdy_q;
        region_q <= cmd_i.region;
        sat_q    <= 1'b0;
        deg_q    <= 1'b0;
      end
      OP_OUT_DEG: begin
        res_q    <= ya_q;
        region_q <= reg_q;
        sat_q    <= 1'b0;
        deg_q    <= 1'b1;
      end
      OP_OUT_LINE: begin
        if (ovf) begin
          res_q <= sum[SumW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        end else begin
          res_q <= sum[DataW-1:0];
        end
        region_q <= reg_q;
        sat_q    <= ovf;
        deg_q    <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.lt        = q_q < $signed(rdx_q);
    stat_o.gt        = q_q > $signed(rdx_q);
    stat_o.hit       = ($signed(rdx_q) == q_q) || (addr_q == '0);
    stat_o.len_zero  = (len_q == '0);
    stat_o.deg       = (xa_q == xb_q);
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.ext_below = ext_below_q;
    stat_o.ext_above = ext_above_q;
  end

  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign region_o       = region_q;
  assign saturated_o    = sat_q;
  assign degenerate_o   = deg_q;

endmodule
`default_nettype wire
